// File: sv/brtd_pkg.sv
// Package for the backlight ramp / timeout dimmer.
// Holds the transfer payload types, operation and register codes, and compare helpers.
// No dependencies.
package brtd_pkg;

  // Operation codes carried in the op field
  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_RAMP    = 3'd1;
  localparam logic [2:0] OP_LIGHT   = 3'd2;
  localparam logic [2:0] OP_OFF     = 3'd3;
  localparam logic [2:0] OP_RESTART = 3'd4;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_TIMEOUT   = 2'd0;
  localparam logic [1:0] REG_BRIGHT    = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;
  localparam logic [1:0] REG_MHZ       = 2'd3;

  // Register reset values
  localparam logic [15:0] TIMEOUT_RST   = 16'd60;
  localparam logic [3:0]  BRIGHT_RST    = 4'd10;
  localparam logic [11:0] THRESHOLD_RST = 12'd2048;
  localparam logic [3:0]  MHZ_RST       = 4'd4;

  // State reset values: timeout plus half brightness, and eight times clock scale
  localparam logic [16:0] COUNT_RST   = 17'd65;
  localparam logic [7:0]  COMPARE_RST = 8'd32;

  localparam logic [3:0] LEVEL_MAX = 4'd10;
  // Compare base used when switching on from dark: 25 - 5/2
  localparam logic [4:0] SWITCH_ON_BASE = 5'd23;

  typedef struct packed {
    logic [2:0]  op;
    logic [11:0] light_level;
    logic        page_is_idle;
  } in_t;

  typedef struct packed {
    logic       pwm_enabled;
    logic [7:0] compare_value;
    logic [3:0] current_level;
    logic       level_reached;
  } out_t;

  // Compare base 25 - (5*level)/2 for levels 0 to 10
  function automatic logic [4:0] level_base(input logic [3:0] level);
    logic [4:0] base;
    case (level)
      4'd0:    base = 5'd25;
      4'd1:    base = 5'd23;
      4'd2:    base = 5'd20;
      4'd3:    base = 5'd18;
      4'd4:    base = 5'd15;
      4'd5:    base = 5'd13;
      4'd6:    base = 5'd10;
      4'd7:    base = 5'd8;
      4'd8:    base = 5'd5;
      4'd9:    base = 5'd3;
      default: base = 5'd0;
    endcase
    return base;
  endfunction

  // Scale a base by the clock, saturating at 255
  function automatic logic [7:0] sat_compare(input logic [4:0] base, input logic [3:0] mhz);
    logic [8:0] prod;
    prod = 9'(base) * 9'(mhz);
    return prod[8] ? 8'hFF : prod[7:0];
  endfunction

endpackage

// File: sv/backlight_ramp_timeout_dimmer_core.sv
// Top level of the backlight ramp / timeout dimmer.
// Input register, single-pass next-state logic, and output register; APB config port.
// Depends on brtd_pkg.
//
// A result passes the input register, then the output register; one operation per cycle
// while the output is not stalled, set by the update of the dimmer state.
// Reset (async, active low) clears both pipeline valids, zeroes levels and the PWM enable,
// loads the countdown with 65 and the compare with 32, and loads register defaults.
module backlight_ramp_timeout_dimmer_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  brtd_pkg::in_t       in_data_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output brtd_pkg::out_t      out_data_o,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // Configuration registers
  logic [15:0] timeout_q;
  logic [3:0]  bright_q;
  logic [11:0] threshold_q;
  logic [3:0]  mhz_q;

  // Pipeline registers
  logic           in_valid_q;
  brtd_pkg::in_t  in_q;
  logic           out_valid_q;
  brtd_pkg::out_t out_q, out_d;

  // Dimmer state
  logic [3:0]  tgt_q, tgt_d;
  logic [3:0]  lvl_q, lvl_d;
  logic        on_q, on_d;
  logic [16:0] cnt_q, cnt_d;
  logic [7:0]  cmp_q, cmp_d;

  logic        out_ready;
  logic        fire;
  logic        cfg_wr;
  logic [3:0]  lit_level;
  logic [16:0] reload;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= brtd_pkg::TIMEOUT_RST;
      bright_q    <= brtd_pkg::BRIGHT_RST;
      threshold_q <= brtd_pkg::THRESHOLD_RST;
      mhz_q       <= brtd_pkg::MHZ_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        brtd_pkg::REG_TIMEOUT:   timeout_q   <= pwdata[15:0];
        brtd_pkg::REG_BRIGHT:    bright_q    <= pwdata[3:0];
        brtd_pkg::REG_THRESHOLD: threshold_q <= pwdata[11:0];
        brtd_pkg::REG_MHZ:       mhz_q       <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    case (paddr[3:2])
      brtd_pkg::REG_TIMEOUT:   prdata = {16'd0, timeout_q};
      brtd_pkg::REG_BRIGHT:    prdata = {28'd0, bright_q};
      brtd_pkg::REG_THRESHOLD: prdata = {20'd0, threshold_q};
      brtd_pkg::REG_MHZ:       prdata = {28'd0, mhz_q};
      default:                 prdata = 32'd0;
    endcase
  end

  // Handshake: the input stage advances whenever the output register is free or draining
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Capture the input payload on each transfer
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  assign lit_level = (bright_q > brtd_pkg::LEVEL_MAX) ? brtd_pkg::LEVEL_MAX : bright_q;
  assign reload    = {1'b0, timeout_q} + 17'(lit_level[3:1]);

  // Next state for the item in the input register
  always_comb begin
    tgt_d = tgt_q;
    lvl_d = lvl_q;
    on_d  = on_q;
    cnt_d = cnt_q;
    cmp_d = cmp_q;
    if (fire) begin
      case (in_q.op)
        brtd_pkg::OP_TICK: begin
          if (cnt_q != 17'd0) begin
            cnt_d = cnt_q - 17'd1;
          end
          if (cnt_d == 17'd0 && in_q.page_is_idle) begin
            tgt_d = 4'd0;
          end
        end
        brtd_pkg::OP_RAMP: begin
          // switch on from dark and reload the timeout
          if (lvl_q == 4'd0 && tgt_q != 4'd0 && !on_q) begin
            cmp_d = brtd_pkg::sat_compare(brtd_pkg::SWITCH_ON_BASE, mhz_q);
            cnt_d = reload;
            on_d  = 1'b1;
          end
          // step one level toward the target
          if (lvl_q < tgt_q) begin
            lvl_d = lvl_q + 4'd1;
            cmp_d = brtd_pkg::sat_compare(brtd_pkg::level_base(lvl_d), mhz_q);
          end else if (lvl_q > tgt_q) begin
            lvl_d = lvl_q - 4'd1;
            cmp_d = brtd_pkg::sat_compare(brtd_pkg::level_base(lvl_d), mhz_q);
          end
          // drop the output once fully dark
          if (lvl_d == 4'd0 && tgt_q == 4'd0) begin
            on_d = 1'b0;
          end
        end
        brtd_pkg::OP_LIGHT: begin
          if (in_q.light_level > threshold_q) begin
            tgt_d = 4'd0;
          end else if (cnt_q != 17'd0) begin
            tgt_d = lit_level;
          end
        end
        brtd_pkg::OP_OFF: begin
          on_d  = 1'b0;
          tgt_d = 4'd0;
          lvl_d = 4'd0;
        end
        brtd_pkg::OP_RESTART: begin
          cnt_d = reload;
        end
        default: ;
      endcase
    end
    out_d.pwm_enabled   = on_d;
    out_d.compare_value = cmp_d;
    out_d.current_level = lvl_d;
    out_d.level_reached = (lvl_d == tgt_d);
  end

  // Hold the dimmer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q <= 4'd0;
      lvl_q <= 4'd0;
      on_q  <= 1'b0;
      cnt_q <= brtd_pkg::COUNT_RST;
      cmp_q <= brtd_pkg::COMPARE_RST;
    end else begin
      tgt_q <= tgt_d;
      lvl_q <= lvl_d;
      on_q  <= on_d;
      cnt_q <= cnt_d;
      cmp_q <= cmp_d;
    end
  end

  // Result register: load on advance, drop after the transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: sv/brtd_checker.sv
// Port-level checker for the backlight dimmer, bound to the top level.
// Depends on brtd_pkg and backlight_ramp_timeout_dimmer_core.
module brtd_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input brtd_pkg::out_t out_data_o
);

  // A stalled result stays offered and unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // Level never passes the saturated maximum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.current_level <= brtd_pkg::LEVEL_MAX)
    else $error("level above maximum");

  // A lit level implies the PWM is driving
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.pwm_enabled |-> out_data_o.current_level == 4'd0)
    else $error("nonzero level with PWM off");

endmodule

bind backlight_ramp_timeout_dimmer_core brtd_checker u_brtd_checker (.*);
